// ----- hw/rtl/rlvd_pkg.sv -----
// Package: shared types, constants and the zigzag table for the coefficient decoder.
package rlvd_pkg;

  localparam int MaxBlocks   = 4096;
  localparam int BlockCoeffs = 64;
  localparam int PosW        = $clog2(BlockCoeffs);
  localparam int OutDepth    = 4;

  typedef enum logic [1:0] {
    CMD_QUANT = 2'd0,
    CMD_START = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_ADD     = 2'd1,
    KIND_END     = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_DC_SIZE = 2'd0,
    PH_DC_AMP  = 2'd1,
    PH_AC_HDR  = 2'd2,
    PH_AC_AMP  = 2'd3
  } phase_t;

  localparam logic CFG_PREDICTED = 1'b0;
  localparam logic CFG_COUNT     = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] stream_byte;
    logic [5:0] quant_index;
    logic [7:0] quant_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        block_number;
    logic [5:0]         position;
    logic signed [23:0] coefficient;
    logic               frame_done;
    logic               last;
  } out_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] stream_byte;
    logic [5:0] quant_index;
    logic [7:0] quant_value;
  } item_t;

  typedef struct packed {
    logic        predicted;
    logic [12:0] count;
  } cfg_t;

  function automatic logic [5:0] zz_natural(input logic [5:0] idx);
    logic [5:0] r;
    unique case (idx)
      6'd0: r = 6'd0;   6'd1: r = 6'd1;   6'd2: r = 6'd8;   6'd3: r = 6'd16;
      6'd4: r = 6'd9;   6'd5: r = 6'd2;   6'd6: r = 6'd3;   6'd7: r = 6'd10;
      6'd8: r = 6'd17;  6'd9: r = 6'd24;  6'd10: r = 6'd32; 6'd11: r = 6'd25;
      6'd12: r = 6'd18; 6'd13: r = 6'd11; 6'd14: r = 6'd4;  6'd15: r = 6'd5;
      6'd16: r = 6'd12; 6'd17: r = 6'd19; 6'd18: r = 6'd26; 6'd19: r = 6'd33;
      6'd20: r = 6'd40; 6'd21: r = 6'd48; 6'd22: r = 6'd41; 6'd23: r = 6'd34;
      6'd24: r = 6'd27; 6'd25: r = 6'd20; 6'd26: r = 6'd13; 6'd27: r = 6'd6;
      6'd28: r = 6'd7;  6'd29: r = 6'd14; 6'd30: r = 6'd21; 6'd31: r = 6'd28;
      6'd32: r = 6'd35; 6'd33: r = 6'd42; 6'd34: r = 6'd49; 6'd35: r = 6'd56;
      6'd36: r = 6'd57; 6'd37: r = 6'd50; 6'd38: r = 6'd43; 6'd39: r = 6'd36;
      6'd40: r = 6'd29; 6'd41: r = 6'd22; 6'd42: r = 6'd15; 6'd43: r = 6'd23;
      6'd44: r = 6'd30; 6'd45: r = 6'd37; 6'd46: r = 6'd44; 6'd47: r = 6'd51;
      6'd48: r = 6'd58; 6'd49: r = 6'd59; 6'd50: r = 6'd52; 6'd51: r = 6'd45;
      6'd52: r = 6'd38; 6'd53: r = 6'd31; 6'd54: r = 6'd39; 6'd55: r = 6'd46;
      6'd56: r = 6'd53; 6'd57: r = 6'd60; 6'd58: r = 6'd61; 6'd59: r = 6'd54;
      6'd60: r = 6'd47; 6'd61: r = 6'd55; 6'd62: r = 6'd62; default: r = 6'd63;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/rlvd_ram.sv -----
// Generic single-write, registered-read RAM.
module rlvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/rlvd_front.sv -----
// Front end: two-entry input queue that classifies each request by command.
module rlvd_front import rlvd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  in_t   in_item,
  output logic  full,
  output logic  item_valid,
  output item_t item,
  input  logic  item_pop
);
  in_t        q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  in_t        head;

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign head       = q[rp];

  always_comb begin
    item.stream_byte = head.stream_byte;
    item.quant_index = head.quant_index;
    item.quant_value = head.quant_value;
    unique case (head.command)
      2'd0:    item.cmd = CMD_QUANT;
      2'd1:    item.cmd = CMD_START;
      2'd2:    item.cmd = CMD_BYTE;
      default: item.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wp] <= in_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (item_pop && item_valid) rp <= ~rp;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((item_pop && item_valid) ? 1 : 0);
    end
  end
endmodule

// ----- hw/rtl/rlvd_out_queue.sv -----
// Result queue: four entries between the decode engine and the consumer.
module rlvd_out_queue import rlvd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  out_t wdata,
  output logic full,
  output logic empty,
  input  logic pop,
  output out_t out_item
);
  localparam int AW = $clog2(OutDepth);

  out_t          q [OutDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign full     = (cnt == (AW+1)'(OutDepth));
  assign empty    = (cnt == '0);
  assign out_item = q[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= wdata;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (pop && !empty) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr ? 1 : 0) - (AW+1)'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ----- hw/rtl/rlvd_engine.sv -----
// Back end: bit buffer, code parser, quant lookup, dequantize multiply and last marking.
module rlvd_engine import rlvd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_pop,
  input  logic  oq_full,
  output logic  oq_wr,
  output out_t  oq_data
);
  typedef struct packed {
    logic               res;
    logic               mark;
    logic [1:0]         kind;
    logic [11:0]        blk;
    logic [5:0]         pos;
    logic               done;
    logic signed [15:0] base;
  } stage_t;

  logic        busy, busy_next;
  logic [23:0] acc, acc_next;
  logic [4:0]  held, held_next;
  phase_t      phase, phase_next;
  logic [3:0]  psize, psize_next, prun, prun_next;
  logic [6:0]  zz, zz_next;
  logic [12:0] bdone, bdone_next;
  logic [15:0] pred, pred_next;
  logic        endp, endp_next;
  stage_t      s1, s1_next;
  out_t        h;
  logic        h_v;

  logic        en, active, can_step, load;
  logic [12:0] eff;
  logic [4:0]  need;
  logic [23:0] shifted;
  logic [14:0] x;
  logic [3:0]  s4, r4;
  logic [15:0] amp, dcsum;
  logic [16:0] half, vl;
  logic [6:0]  idx;
  logic [5:0]  raddr;
  logic        we;
  logic [7:0]  q;
  logic signed [24:0] prod;

  assign en     = !oq_full;
  assign eff    = (cfg.count > 13'(MaxBlocks)) ? 13'(MaxBlocks) : cfg.count;
  assign active = (bdone < eff);

  always_comb begin
    unique case (phase)
      PH_DC_SIZE: need = 5'd4;
      PH_AC_HDR:  need = 5'd8;
      default:    need = {1'b0, psize};
    endcase
  end

  assign can_step = active && (endp || held >= need);
  assign shifted  = acc >> (held - need);
  assign x        = shifted[14:0] & ((15'd1 << psize) - 15'd1);
  assign s4       = shifted[3:0];
  assign r4       = shifted[7:4];
  assign half     = 17'd1 << (psize - 4'd1);
  assign vl       = ({2'b00, x} < half) ? ({2'b00, x} - ((17'd1 << psize) - 17'd1))
                                        : {2'b00, x};
  assign amp      = vl[15:0];
  assign idx      = zz + {3'b000, prun};

  always_comb begin
    busy_next  = busy;
    acc_next   = acc;
    held_next  = held;
    phase_next = phase;
    psize_next = psize;
    prun_next  = prun;
    zz_next    = zz;
    bdone_next = bdone;
    pred_next  = pred;
    endp_next  = endp;
    s1_next    = '0;
    s1_next.blk = bdone[11:0];
    raddr      = '0;
    we         = 1'b0;
    load       = 1'b0;
    dcsum      = '0;
    item_pop   = 1'b0;
    if (en) begin
      if (busy && can_step) begin
        held_next = held - (endp ? 5'd0 : need);
        if (endp) begin
          s1_next.res  = 1'b1;
          s1_next.kind = KIND_END;
          endp_next    = 1'b0;
        end else begin
          unique case (phase)
            PH_DC_SIZE: begin
              if (s4 == 4'd0) begin
                s1_next.res  = 1'b1;
                s1_next.kind = cfg.predicted ? KIND_ADD : KIND_WRITE;
                s1_next.base = cfg.predicted ? 16'sd0 : $signed(pred);
                phase_next   = PH_AC_HDR;
              end else begin
                psize_next = s4;
                phase_next = PH_DC_AMP;
              end
            end
            PH_DC_AMP: begin
              dcsum        = pred + amp;
              s1_next.res  = 1'b1;
              s1_next.kind = cfg.predicted ? KIND_ADD : KIND_WRITE;
              s1_next.base = cfg.predicted ? $signed(amp) : $signed(dcsum);
              if (!cfg.predicted) pred_next = dcsum;
              phase_next   = PH_AC_HDR;
            end
            PH_AC_HDR: begin
              if (s4 != 4'd0) begin
                prun_next  = r4;
                psize_next = s4;
                phase_next = PH_AC_AMP;
              end else if (r4 == 4'd15 && zz + 7'd16 <= 7'd63) begin
                zz_next = zz + 7'd16;
              end else begin
                s1_next.res  = 1'b1;
                s1_next.kind = (r4 == 4'd15) ? KIND_OVERRUN : KIND_END;
              end
            end
            default: begin
              if (idx > 7'd63) begin
                s1_next.res  = 1'b1;
                s1_next.kind = KIND_OVERRUN;
              end else begin
                raddr        = zz_natural(idx[5:0]);
                s1_next.res  = 1'b1;
                s1_next.kind = cfg.predicted ? KIND_ADD : KIND_WRITE;
                s1_next.pos  = raddr;
                s1_next.base = $signed(amp);
                phase_next   = PH_AC_HDR;
                if (idx == 7'd63) endp_next = 1'b1;
                else zz_next = idx + 7'd1;
              end
            end
          endcase
        end
        if (s1_next.res && (s1_next.kind == KIND_END || s1_next.kind == KIND_OVERRUN)) begin
          s1_next.done = ({1'b0, bdone} + 14'd1 >= {1'b0, eff});
          bdone_next   = bdone + 13'd1;
          phase_next   = PH_DC_SIZE;
          zz_next      = 7'd1;
          psize_next   = '0;
          prun_next    = '0;
          if (s1_next.done) begin
            acc_next  = '0;
            held_next = '0;
          end
        end
      end else begin
        if (busy) begin
          s1_next.mark = 1'b1;
          busy_next    = 1'b0;
        end
        load = item_valid;
      end
    end
    if (load) begin
      item_pop = 1'b1;
      unique case (item.cmd)
        CMD_QUANT: we = 1'b1;
        CMD_START: begin
          pred_next  = '0;
          acc_next   = '0;
          held_next  = '0;
          phase_next = PH_DC_SIZE;
          psize_next = '0;
          prun_next  = '0;
          zz_next    = 7'd1;
          bdone_next = '0;
          endp_next  = 1'b0;
        end
        CMD_BYTE: begin
          if (active) begin
            acc_next  = {acc[15:0], item.stream_byte};
            held_next = held + 5'd8;
            busy_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  rlvd_ram #(.WIDTH(8), .DEPTH(BlockCoeffs)) u_quant (
    .clk   (clk),
    .we    (we),
    .waddr (item.quant_index),
    .wdata (item.quant_value),
    .re    (en),
    .raddr (raddr),
    .rdata (q)
  );

  assign prod = s1.base * $signed({1'b0, q});

  always_comb begin
    oq_wr   = 1'b0;
    oq_data = h;
    if (en && h_v && (s1.res || s1.mark)) begin
      oq_wr        = 1'b1;
      oq_data.last = s1.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1.res) begin
      h.kind         <= s1.kind;
      h.block_number <= s1.blk;
      h.position     <= s1.pos;
      h.coefficient  <= prod[23:0];
      h.frame_done   <= s1.done;
      h.last         <= 1'b0;
    end
    if (rst) begin
      busy  <= 1'b0;
      acc   <= '0;
      held  <= '0;
      phase <= PH_DC_SIZE;
      psize <= '0;
      prun  <= '0;
      zz    <= 7'd1;
      bdone <= '0;
      pred  <= '0;
      endp  <= 1'b0;
      s1    <= '0;
      h_v   <= 1'b0;
    end else begin
      busy  <= busy_next;
      acc   <= acc_next;
      held  <= held_next;
      phase <= phase_next;
      psize <= psize_next;
      prun  <= prun_next;
      zz    <= zz_next;
      bdone <= bdone_next;
      pred  <= pred_next;
      endp  <= endp_next;
      if (en) begin
        s1 <= s1_next;
        if (s1.res) h_v <= 1'b1;
        else if (s1.mark) h_v <= 1'b0;
      end
    end
  end

  a_stage_one_kind: assert property (@(posedge clk) disable iff (rst) !(s1.res && s1.mark))
    else $error("stage carries a result and a marker together");
  a_endp_phase: assert property (@(posedge clk) disable iff (rst)
    endp |-> (phase == PH_AC_HDR && busy))
    else $error("pending block end outside AC header phase");
  a_held_range: assert property (@(posedge clk) disable iff (rst) held <= 5'd24)
    else $error("bit buffer overfilled");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    oq_full |=> $stable(s1) && $stable(h_v))
    else $error("pipeline moved while result queue full");
endmodule

// ----- hw/rtl/run_length_vli_coefficient_decoder_unit.sv -----
// Top level: run-length / VLI coefficient decoder with config registers and queues.
// Usage:
//  Input queue: drive in_item and push; a request is taken when push is high and
//  full is low. Commands load a quant entry, start a frame or supply a stream byte.
//  Result queue: while empty is low, out_item is the oldest result; pop takes it.
//  Config: cfg_valid/cfg_ready with cfg_index (0 frame type, 1 block count) and
//  cfg_data; cfg_ready is always high. Write only while the block is idle.
//  Decoding: a stream byte is loaded, then parsed one code per cycle while the
//  result queue is not full, then closed; closing overlaps with loading the
//  next request. The last result of a byte is held until the byte is finished,
//  so it is marked last.
//  Reset clears all control state, the bit buffer and the predictor; quant entries
//  are undefined until loaded.
//  When pop stays low the four-entry result queue fills, the decoder halts, the
//  two-entry input queue fills and full rises; nothing is lost.
module run_length_vli_coefficient_decoder_unit import rlvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  in_t         in_item,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_t        out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  cfg_t  cfg;
  logic  item_valid, item_pop, oq_full, oq_wr;
  item_t item;
  out_t  oq_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PREDICTED: cfg.predicted <= cfg_data[0];
        default:       cfg.count     <= cfg_data;
      endcase
    end
  end

  rlvd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_item    (in_item),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  rlvd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .oq_full    (oq_full),
    .oq_wr      (oq_wr),
    .oq_data    (oq_data)
  );

  rlvd_out_queue u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr       (oq_wr),
    .wdata    (oq_data),
    .full     (oq_full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );
endmodule
